FILE: hdl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types, register indexes and constants of the ADSR envelope level core.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 25;
    localparam int DIV_W     = 24;   // divisor and remainder width
    localparam int DIV_STEPS = 30;   // quotient bits per division
    localparam int EXP_SHIFT = 30;
    localparam int MAX_ROOTS = 12;
    localparam int ROOT_W    = 30;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    localparam logic [CFG_AW-1:0] REG_ATTACK_LEN    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_DECAY_LEN     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SUSTAIN_LEN   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_SUSTAIN_LEVEL = 3'd3;
    localparam logic [CFG_AW-1:0] REG_RELEASE_TAU   = 3'd4;

    // codes equal the phase number on the output
    typedef enum logic [1:0] {
        MODE_ATTACK  = 2'd0,
        MODE_DECAY   = 2'd1,
        MODE_LEVEL   = 2'd2,
        MODE_RELEASE = 2'd3
    } t_mode;

    // flag: decay before attack end (gain is one), or release underflow
    typedef struct packed {
        t_mode mode;
        logic  flag;
    } t_ctl;

    typedef struct packed {
        logic [23:0] attack_len;
        logic [23:0] decay_len;
        logic [24:0] dec_end;
        logic [25:0] sus_end;
        logic        sus_inf;
        logic [23:0] tau1;
    } t_cfg;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = '0;
        b   = 64'd1 << 62;
        rem = val;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // root i = 2^(-2^-i) in Q30, packed with root 1 at the bottom
    function automatic logic [MAX_ROOTS*ROOT_W-1:0] exp_roots();
        logic [MAX_ROOTS*ROOT_W-1:0] res;
        logic [63:0]                 r;
        res = '0;
        r   = isqrt64(64'd1 << 59);
        for (int i = 0; i < MAX_ROOTS; i++) begin
            res[i*ROOT_W +: ROOT_W] = r[ROOT_W-1:0];
            r = isqrt64(r << 30);
        end
        return res;
    endfunction

endpackage

FILE: hdl/adsr_front.sv
// ----------------------------------------------------------------------------
// adsr_front
// Phase decode and divider operand setup: input register, phase decode, and
// the decay product / release underflow stage.
// ----------------------------------------------------------------------------
module adsr_front #(
    parameter int IW = 32,
    parameter int LW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [IW-1:0]           i_t,
    input  adsr_pkg::t_cfg          i_cfg,
    input  logic [LW-1:0]           i_oml,
    output logic                    o_valid,
    output adsr_pkg::t_ctl          o_ctl,
    output logic [adsr_pkg::DIV_W-1:0]     o_rem,
    output logic [adsr_pkg::DIV_STEPS-1:0] o_bits,
    output logic [adsr_pkg::DIV_W-1:0]     o_div
);
    import adsr_pkg::*;

    localparam int XW = (IW > 26) ? IW : 26;
    localparam int UW = (IW > 30) ? IW : 30;
    localparam int MW = LW + 24;

    // stage 0: input word
    logic          r_s0_valid;
    logic [IW-1:0] r_s0_t;

    // stage 1: decoded phase
    logic          r_s1_valid;
    t_ctl          r_s1_ctl;
    logic [IW-1:0] r_s1_opa;
    t_ctl          n_s1_ctl;
    logic [IW-1:0] n_s1_opa;

    logic [XW-1:0] tx;
    logic          is_atk;
    logic          is_dec;

    // stage 2 logic
    logic [MW-1:0]        prod;
    logic                 under;
    t_ctl                 n_s2_ctl;
    logic [DIV_W-1:0]     n_s2_rem;
    logic [DIV_STEPS-1:0] n_s2_bits;
    logic [DIV_W-1:0]     n_s2_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            o_valid    <= r_s1_valid;
        end
    end

    always_comb begin
        tx     = XW'(r_s0_t);
        is_atk = (tx < XW'(i_cfg.attack_len)) && (i_cfg.attack_len > 24'd1);
        is_dec = (tx < XW'(i_cfg.dec_end)) && (i_cfg.decay_len > 24'd1);
        n_s1_ctl.flag = 1'b0;
        n_s1_opa      = r_s0_t;
        priority if (is_atk) begin
            n_s1_ctl.mode = MODE_ATTACK;
        end else if (is_dec) begin
            // index 0 with a one-sample attack lands here: gain clamps to one
            n_s1_ctl.mode = MODE_DECAY;
            n_s1_ctl.flag = tx < XW'(i_cfg.attack_len);
            n_s1_opa      = IW'(tx - XW'(i_cfg.attack_len));
        end else if (i_cfg.sus_inf || (tx < XW'(i_cfg.sus_end))) begin
            n_s1_ctl.mode = MODE_LEVEL;
        end else begin
            n_s1_ctl.mode = MODE_RELEASE;
            n_s1_opa      = IW'(tx - XW'(i_cfg.sus_end));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_t   <= i_t;
        r_s1_ctl <= n_s1_ctl;
        r_s1_opa <= n_s1_opa;
    end

    always_comb begin
        prod      = MW'(i_oml) * MW'(24'(r_s1_opa));
        under     = UW'(r_s1_opa) >= UW'({i_cfg.tau1, 6'b0});
        n_s2_ctl  = r_s1_ctl;
        n_s2_rem  = '0;
        n_s2_bits = '0;
        n_s2_div  = i_cfg.tau1;
        unique case (r_s1_ctl.mode)
            MODE_ATTACK: begin
                n_s2_rem = DIV_W'(r_s1_opa);
                n_s2_div = i_cfg.attack_len;
            end
            MODE_DECAY: begin
                n_s2_rem  = DIV_W'(prod >> DIV_STEPS);
                n_s2_bits = DIV_STEPS'(prod);
                n_s2_div  = i_cfg.decay_len;
            end
            MODE_RELEASE: begin
                // quotient bits 29:24 give d / tau, the rest the fraction
                n_s2_rem      = DIV_W'(r_s1_opa >> 6);
                n_s2_bits     = {6'(r_s1_opa), 24'b0};
                n_s2_ctl.flag = under;
            end
            default: begin
                n_s2_rem = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_ctl  <= n_s2_ctl;
        o_rem  <= n_s2_rem;
        o_bits <= n_s2_bits;
        o_div  <= n_s2_div;
    end

endmodule

FILE: hdl/adsr_div.sv
// ----------------------------------------------------------------------------
// adsr_div
// Pipelined restoring divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
module adsr_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  adsr_pkg::t_ctl                 i_ctl,
    input  logic [adsr_pkg::DIV_W-1:0]     i_rem,
    input  logic [adsr_pkg::DIV_STEPS-1:0] i_bits,
    input  logic [adsr_pkg::DIV_W-1:0]     i_div,
    output logic                           o_valid,
    output adsr_pkg::t_ctl                 o_ctl,
    output logic [adsr_pkg::DIV_STEPS-1:0] o_quo
);
    import adsr_pkg::*;

    logic                 r_valid [DIV_STEPS];
    t_ctl                 r_ctl   [DIV_STEPS];
    logic [DIV_W-1:0]     r_rem   [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_bits  [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo   [DIV_STEPS];
    logic [DIV_W-1:0]     r_div   [DIV_STEPS];

    logic [DIV_W-1:0]     n_rem   [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_quo   [DIV_STEPS];

    always_comb begin
        logic [DIV_W-1:0]     s_rem;
        logic [DIV_STEPS-1:0] s_bits;
        logic [DIV_STEPS-1:0] s_quo;
        logic [DIV_W-1:0]     s_div;
        logic [DIV_W:0]       sh;
        logic                 ge;
        for (int j = 0; j < DIV_STEPS; j++) begin
            s_rem  = (j == 0) ? i_rem  : r_rem[j-1];
            s_bits = (j == 0) ? i_bits : r_bits[j-1];
            s_quo  = (j == 0) ? '0     : r_quo[j-1];
            s_div  = (j == 0) ? i_div  : r_div[j-1];
            sh     = {s_rem, s_bits[DIV_STEPS-1]};
            ge     = sh >= {1'b0, s_div};
            n_rem[j] = ge ? DIV_W'(sh - {1'b0, s_div}) : sh[DIV_W-1:0];
            n_quo[j] = {s_quo[DIV_STEPS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_valid[j] <= 1'b0;
            end
        end else begin
            r_valid[0] <= i_valid;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_valid[j] <= r_valid[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DIV_STEPS; j++) begin
            r_rem[j] <= n_rem[j];
            r_quo[j] <= n_quo[j];
        end
        r_ctl[0]  <= i_ctl;
        r_bits[0] <= {i_bits[DIV_STEPS-2:0], 1'b0};
        r_div[0]  <= i_div;
        for (int j = 1; j < DIV_STEPS; j++) begin
            r_ctl[j]  <= r_ctl[j-1];
            r_bits[j] <= {r_bits[j-1][DIV_STEPS-2:0], 1'b0};
            r_div[j]  <= r_div[j-1];
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_ctl   = r_ctl[DIV_STEPS-1];
    assign o_quo   = r_quo[DIV_STEPS-1];

endmodule

FILE: hdl/adsr_exp.sv
// ----------------------------------------------------------------------------
// adsr_exp
// Back end: ramp gains from the quotient, and the release power of two built
// as a chain of root products, one table bit per stage.
// ----------------------------------------------------------------------------
module adsr_exp #(
    parameter int GF = 15,
    parameter int L  = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  adsr_pkg::t_ctl                 i_ctl,
    input  logic [adsr_pkg::DIV_STEPS-1:0] i_quo,
    input  logic [GF:0]                    i_lvl,
    output logic                           o_valid,
    output adsr_pkg::t_mode                o_mode,
    output logic [GF:0]                    o_gain
);
    import adsr_pkg::*;

    localparam int LW = GF + 1;
    localparam logic [LW-1:0] ONE = LW'(1) << GF;
    localparam logic [MAX_ROOTS*ROOT_W-1:0] ROOTS = exp_roots();

    // log2 stage
    logic          r_y_valid;
    t_ctl          r_y_ctl;
    logic [30:0]   r_y;
    logic [LW-1:0] r_y_g;
    logic [LW-1:0] n_y_g;

    // root product stages
    logic          r_valid [L];
    t_ctl          r_ctl   [L];
    logic [30:0]   r_acc   [L];
    logic [6:0]    r_n     [L];
    logic [L-1:0]  r_k     [L];
    logic [LW-1:0] r_g     [L];
    logic [30:0]   n_acc   [L];

    // level product stage
    logic          r_v_valid;
    t_ctl          r_v_ctl;
    logic [LW-1:0] r_v;
    logic [6:0]    r_v_n;
    logic [LW-1:0] r_v_g;

    logic [60:0]   ylog;

    always_comb begin
        ylog = 61'(i_quo) * 61'(LOG2E_Q30);
        unique case (i_ctl.mode)
            MODE_ATTACK: n_y_g = LW'(i_quo >> (DIV_STEPS - GF));
            MODE_DECAY:  n_y_g = i_ctl.flag ? ONE : ONE - LW'(i_quo);
            MODE_LEVEL:  n_y_g = i_lvl;
            default:     n_y_g = '0;
        endcase
    end

    always_comb begin
        logic [30:0]  s_acc;
        logic [L-1:0] s_k;
        logic [60:0]  prod;
        for (int j = 0; j < L; j++) begin
            s_acc = (j == 0) ? (31'd1 << EXP_SHIFT) : r_acc[j-1];
            s_k   = (j == 0) ? r_y[23 -: L] : r_k[j-1];
            prod  = 61'(s_acc) * 61'(ROOTS[j*ROOT_W +: ROOT_W]);
            n_acc[j] = s_k[L-1-j] ? 31'(prod >> EXP_SHIFT) : s_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_valid <= 1'b0;
            for (int j = 0; j < L; j++) begin
                r_valid[j] <= 1'b0;
            end
            r_v_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_y_valid  <= i_valid;
            r_valid[0] <= r_y_valid;
            for (int j = 1; j < L; j++) begin
                r_valid[j] <= r_valid[j-1];
            end
            r_v_valid <= r_valid[L-1];
            o_valid   <= r_v_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y_ctl <= i_ctl;
        r_y     <= 31'(ylog >> EXP_SHIFT);
        r_y_g   <= n_y_g;

        for (int j = 0; j < L; j++) begin
            r_acc[j] <= n_acc[j];
        end
        r_ctl[0] <= r_y_ctl;
        r_n[0]   <= r_y[30:24];
        r_k[0]   <= r_y[23 -: L];
        r_g[0]   <= r_y_g;
        for (int j = 1; j < L; j++) begin
            r_ctl[j] <= r_ctl[j-1];
            r_n[j]   <= r_n[j-1];
            r_k[j]   <= r_k[j-1];
            r_g[j]   <= r_g[j-1];
        end

        r_v_ctl <= r_ctl[L-1];
        r_v     <= LW'((55'(i_lvl) * 55'(r_acc[L-1])) >> EXP_SHIFT);
        r_v_n   <= r_n[L-1];
        r_v_g   <= r_g[L-1];

        o_mode <= r_v_ctl.mode;
        if (r_v_ctl.mode != MODE_RELEASE) begin
            o_gain <= r_v_g;
        end else if (r_v_ctl.flag || r_v_n[6]) begin
            // flush to zero on underflow
            o_gain <= '0;
        end else begin
            o_gain <= r_v >> r_v_n;
        end
    end

endmodule

FILE: hdl/adsr_envelope_level_core.sv
// ----------------------------------------------------------------------------
// adsr_envelope_level_core
// ADSR envelope gain in unsigned Q1.GAIN_FRAC_BITS from a sample index.
// ----------------------------------------------------------------------------
// Takes one sample index in every clock cycle; busy is held low. Each gain
// appears on o_gain/o_phase with o_strobe exactly 36 + log2(EXP_TABLE_DEPTH)
// cycles after start is taken (44 at the defaults), in order, and must be
// captured in that cycle. The latency is set by the 30-stage divider shared
// by the attack ramp, the decay ramp and the release time scaling, and by
// one root-product stage per bit of the exponent table index.
// EXP_TABLE_DEPTH must be a power of two. Write registers only while no word
// is in flight.
module adsr_envelope_level_core #(
    parameter int INDEX_WIDTH     = 32,
    parameter int GAIN_FRAC_BITS  = 15,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [31:0]                 i_sample_index,
    input  logic                        i_cfg_we,
    input  logic [adsr_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [adsr_pkg::CFG_DW-1:0] i_cfg_data,
    output logic                        o_strobe,
    output logic [15:0]                 o_gain,
    output logic [1:0]                  o_phase
);
    import adsr_pkg::*;

    localparam int LW  = GAIN_FRAC_BITS + 1;
    localparam int L   = $clog2(EXP_TABLE_DEPTH);
    localparam int LAT = 3 + DIV_STEPS + 1 + L + 2;
    localparam logic [LW-1:0] ONE = LW'(1) << GAIN_FRAC_BITS;

    logic [23:0] r_attack_len;
    logic [23:0] r_decay_len;
    logic [24:0] r_sustain_len;
    logic [15:0] r_sustain_level;
    logic [23:0] r_release_tau;

    t_cfg          r_cfg;
    logic [LW-1:0] r_lvl;
    logic [LW-1:0] r_oml;
    logic [LW-1:0] n_lvl;

    logic                 f_valid;
    t_ctl                 f_ctl;
    logic [DIV_W-1:0]     f_rem;
    logic [DIV_STEPS-1:0] f_bits;
    logic [DIV_W-1:0]     f_div;

    logic                 d_valid;
    t_ctl                 d_ctl;
    logic [DIV_STEPS-1:0] d_quo;

    t_mode         x_mode;
    logic [LW-1:0] x_gain;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_len    <= '0;
            r_decay_len     <= '0;
            r_sustain_len   <= '1;
            r_sustain_level <= 16'd32768;
            r_release_tau   <= 24'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ATTACK_LEN:    r_attack_len    <= i_cfg_data[23:0];
                REG_DECAY_LEN:     r_decay_len     <= i_cfg_data[23:0];
                REG_SUSTAIN_LEN:   r_sustain_len   <= i_cfg_data;
                REG_SUSTAIN_LEVEL: r_sustain_level <= i_cfg_data[15:0];
                REG_RELEASE_TAU:   r_release_tau   <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // derived settings, registered from the config registers
    assign n_lvl = (32'(r_sustain_level) > 32'(ONE)) ? ONE : LW'(r_sustain_level);

    always_ff @(posedge i_clk) begin
        r_cfg.attack_len <= r_attack_len;
        r_cfg.decay_len  <= r_decay_len;
        r_cfg.dec_end    <= 25'(r_attack_len) + 25'(r_decay_len);
        r_cfg.sus_end    <= 26'(r_attack_len) + 26'(r_decay_len)
                            + 26'(r_sustain_len[23:0]);
        r_cfg.sus_inf    <= r_sustain_len[24];
        r_cfg.tau1       <= (r_release_tau == '0) ? 24'd1 : r_release_tau;
        r_lvl            <= n_lvl;
        r_oml            <= ONE - n_lvl;
    end

    adsr_front #(
        .IW (INDEX_WIDTH),
        .LW (LW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_t     (INDEX_WIDTH'(i_sample_index)),
        .i_cfg   (r_cfg),
        .i_oml   (r_oml),
        .o_valid (f_valid),
        .o_ctl   (f_ctl),
        .o_rem   (f_rem),
        .o_bits  (f_bits),
        .o_div   (f_div)
    );

    adsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_ctl   (f_ctl),
        .i_rem   (f_rem),
        .i_bits  (f_bits),
        .i_div   (f_div),
        .o_valid (d_valid),
        .o_ctl   (d_ctl),
        .o_quo   (d_quo)
    );

    adsr_exp #(
        .GF (GAIN_FRAC_BITS),
        .L  (L)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_ctl   (d_ctl),
        .i_quo   (d_quo),
        .i_lvl   (r_lvl),
        .o_valid (o_strobe),
        .o_mode  (x_mode),
        .o_gain  (x_gain)
    );

    assign o_gain  = 16'(x_gain);
    assign o_phase = x_mode;

`ifndef SYNTHESIS
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("accepted word produced no gain at fixed latency");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("gain strobe without matching accepted word");

    a_attack_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_phase == MODE_ATTACK)) |->
            ((GAIN_FRAC_BITS > 15) || (32'(o_gain) < 32'(ONE))))
        else $error("attack gain reached one");
`endif

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADSR envelope level core: a directed table of
// register settings and sample indexes, then ten configurations (two fixed,
// eight random), each with random indexes. Every gain/phase word is checked in
// order against the table's word or a behavioral predictor of the envelope.
// ----------------------------------------------------------------------------
module tb_top;
    import adsr_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int N_ROOTS     = 24;
    localparam int WDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS = 10;
    localparam logic [15:0] GAIN_ONE = 16'd32768;
    localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd5;

    typedef struct {
        logic [15:0] gain;
        t_mode       mode;
    } t_env_word;

    typedef struct {
        bit              is_cfg;
        logic [CFG_AW-1:0] reg_idx;
        logic [31:0]     val;
        bit              typed;
        logic [15:0]     gain;
        t_mode           mode;
    } t_step;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [31:0]         i_sample_index;
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_index;
    logic [CFG_DW-1:0]   i_cfg_data;
    logic                o_strobe;
    logic [15:0]         o_gain;
    logic [1:0]          o_phase;

    adsr_envelope_level_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_sample_index(i_sample_index), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_gain(o_gain), .o_phase(o_phase)
    );

    // envelope settings as the core should hold them
    logic [23:0]        env_attack;
    logic [23:0]        env_decay;
    logic signed [24:0] env_sus_len;
    logic [15:0]        env_level;
    logic [23:0]        env_tau;

    logic [63:0] exp_root [1:N_ROOTS];
    t_env_word   pending_words [$];
    int          n_taken;
    int          n_errors;
    int          idle_cycles;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] release_level(input logic [63:0] lvl,
                                                  input logic [63:0] d,
                                                  input logic [63:0] tau);
        logic [63:0] q, r, x, y, n, f, k, g, acc;
        q = d / tau;
        r = d % tau;
        if (q >= 64) return 0;
        x = (q << 24) + ((r << 24) / tau);
        y = (x * 64'(LOG2E_Q30)) >> 30;
        n = y >> 24;
        f = y & 64'hFFFFFF;
        k = (f * TABLE_DEPTH) >> 24;
        g = (k << 24) / TABLE_DEPTH;
        acc = 64'd1 << 30;
        for (int i = 1; i <= N_ROOTS; i++)
            if (g[N_ROOTS-i]) acc = (acc * exp_root[i]) >> 30;
        if (n >= 64) return 0;
        return ((lvl * acc) >> 30) >> n;
    endfunction

    function automatic t_env_word envelope_at(input logic [31:0] idx);
        t_env_word   w;
        logic [63:0] t, lvl, tau, dec_end, sus_end;
        longint      num, gs;
        t       = 64'(idx);
        lvl     = (env_level > GAIN_ONE) ? 64'(GAIN_ONE) : 64'(env_level);
        tau     = (env_tau == 0) ? 64'd1 : 64'(env_tau);
        dec_end = 64'(env_attack) + 64'(env_decay);
        if (t < env_attack && env_attack > 1) begin
            w.gain = 16'((t * GAIN_ONE) / env_attack);
            w.mode = MODE_ATTACK;
        end else if (t < dec_end && env_decay > 1) begin
            num = (longint'(lvl) - longint'(GAIN_ONE)) *
                  (longint'(t) - longint'(env_attack));
            gs = longint'(GAIN_ONE) + num / longint'(env_decay);
            if (gs < 0) gs = 0;
            if (gs > longint'(GAIN_ONE)) gs = longint'(GAIN_ONE);
            w.gain = 16'(gs);
            w.mode = MODE_DECAY;
        end else if (env_sus_len < 0) begin
            w.gain = 16'(lvl);
            w.mode = MODE_LEVEL;
        end else begin
            sus_end = dec_end + 64'(env_sus_len);
            if (t < sus_end) begin
                w.gain = 16'(lvl);
                w.mode = MODE_LEVEL;
            end else begin
                w.gain = 16'(release_level(lvl, t - sus_end, tau));
                w.mode = MODE_RELEASE;
            end
        end
        return w;
    endfunction

    // count accepted sample indexes
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) n_taken = n_taken + 1;
    end

    always @(posedge i_clk) begin
        t_env_word w;
        if (i_rst_n && o_strobe) begin
            if (pending_words.size() == 0) begin
                n_errors = n_errors + 1;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected word: gain %0d phase %0d", o_gain, o_phase);
            end else begin
                w = pending_words.pop_front();
                if (o_gain !== w.gain || o_phase !== w.mode) begin
                    n_errors = n_errors + 1;
                    if (n_errors <= MAX_REPORTS)
                        $display("mismatch: exp gain %0d phase %0d, got gain %0d phase %0d",
                                 w.gain, w.mode, o_gain, o_phase);
                end
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // drive one index; called at a falling edge, returns at a falling edge
    task automatic send_index(input logic [31:0] idx, input bit typed,
                              input logic [15:0] g, input t_mode m);
        t_env_word w;
        int        target;
        target = n_taken + 1;
        start          <= 1'b1;
        i_sample_index <= idx;
        if (typed) begin
            w.gain = g;
            w.mode = m;
        end else begin
            w = envelope_at(idx);
        end
        @(negedge i_clk);
        while (n_taken < target) @(negedge i_clk);
        pending_words.push_back(w);
    endtask

    // hold off until every word in flight has come back
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_ATTACK_LEN:    env_attack  = data[23:0];
            REG_DECAY_LEN:     env_decay   = data[23:0];
            REG_SUSTAIN_LEN:   env_sus_len = data[24:0];
            REG_SUSTAIN_LEVEL: env_level   = data[15:0];
            REG_RELEASE_TAU:   env_tau     = data[23:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [CFG_DW-1:0] pick_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DW'(1);
            2: return 25'hFFFFFF;
            3: return CFG_DW'($urandom);
            default: return CFG_DW'($urandom_range(2, 300));
        endcase
    endfunction

    task automatic random_config();
        logic [CFG_DW-1:0] d;
        write_reg(REG_ATTACK_LEN, pick_len());
        write_reg(REG_DECAY_LEN, pick_len());
        case ($urandom_range(0, 5))
            0: d = '1;
            1: d = {1'b1, 24'($urandom)};
            2: d = 25'hFFFFFF;
            default: d = CFG_DW'($urandom_range(0, 400));
        endcase
        write_reg(REG_SUSTAIN_LEN, d);
        case ($urandom_range(0, 5))
            0: d = CFG_DW'(GAIN_ONE);
            1: d = CFG_DW'($urandom);
            2: d = '0;
            default: d = CFG_DW'($urandom_range(0, 32768));
        endcase
        write_reg(REG_SUSTAIN_LEVEL, d);
        case ($urandom_range(0, 7))
            0: d = '0;
            1: d = CFG_DW'(1);
            2: d = 25'hFFFFFF;
            3: d = CFG_DW'($urandom);
            default: d = CFG_DW'($urandom_range(2, 2000));
        endcase
        write_reg(REG_RELEASE_TAU, d);
        write_reg(CFG_AW'($urandom_range(REG_SPARE_LO, 7)), CFG_DW'($urandom));
    endtask

    function automatic logic [31:0] pick_index();
        longint dec_end, sus_end, tau;
        dec_end = longint'(env_attack) + longint'(env_decay);
        sus_end = dec_end + ((env_sus_len < 0) ? 0 : longint'(env_sus_len));
        tau     = (env_tau == 0) ? 1 : longint'(env_tau);
        if (tau > 50000) tau = 50000;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1, 2: return $urandom_range(0, 32'(dec_end + 2));
            default: return 32'(sus_end + $urandom_range(0, 32'(70 * tau + 5)));
        endcase
    endfunction

    t_step steps [$];

    initial begin
        t_step s;
        bit    no_gaps;
        logic [63:0] r;
        r = sqrt_floor(64'd1 << 59);
        for (int i = 1; i <= N_ROOTS; i++) begin
            exp_root[i] = r;
            r = sqrt_floor(r << 30);
        end
        env_attack  = 0;
        env_decay   = 0;
        env_sus_len = -1;
        env_level   = GAIN_ONE;
        env_tau     = 1;
        n_taken     = 0;
        n_errors    = 0;
        idle_cycles = 0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_sample_index <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;

        // reset values, ramps, release, level above one, zero tau,
        // short ramps, decay ahead of attack end, underflow
        steps = '{
            '{0, 0, 32'd0,          1, GAIN_ONE, MODE_LEVEL},
            '{0, 0, 32'hFFFFFFFF,   1, GAIN_ONE, MODE_LEVEL},
            '{1, REG_ATTACK_LEN,    32'd100, 0, 0, MODE_ATTACK},
            '{1, REG_DECAY_LEN,     32'd100, 0, 0, MODE_ATTACK},
            '{1, REG_SUSTAIN_LEN,   32'd50,  0, 0, MODE_ATTACK},
            '{1, REG_SUSTAIN_LEVEL, 32'd16384, 0, 0, MODE_ATTACK},
            '{1, REG_RELEASE_TAU,   32'd10,  0, 0, MODE_ATTACK},
            '{0, 0, 32'd0,          1, 16'd0,     MODE_ATTACK},
            '{0, 0, 32'd50,         1, 16'd16384, MODE_ATTACK},
            '{0, 0, 32'd99,         0, 0, MODE_ATTACK},
            '{0, 0, 32'd100,        1, GAIN_ONE,  MODE_DECAY},
            '{0, 0, 32'd150,        0, 0, MODE_ATTACK},
            '{0, 0, 32'd249,        1, 16'd16384, MODE_LEVEL},
            '{0, 0, 32'd250,        1, 16'd16384, MODE_RELEASE},
            '{0, 0, 32'd260,        0, 0, MODE_ATTACK},
            '{0, 0, 32'hFFFFFFFF,   1, 16'd0,     MODE_RELEASE},
            '{1, REG_SUSTAIN_LEVEL, 32'hFFFF, 0, 0, MODE_ATTACK},
            '{1, REG_RELEASE_TAU,   32'd0,   0, 0, MODE_ATTACK},
            '{1, REG_ATTACK_LEN,    32'd1,   0, 0, MODE_ATTACK},
            '{1, REG_DECAY_LEN,     32'd1,   0, 0, MODE_ATTACK},
            '{1, REG_SUSTAIN_LEN,   32'd0,   0, 0, MODE_ATTACK},
            '{0, 0, 32'd0,          1, GAIN_ONE, MODE_LEVEL},
            '{0, 0, 32'd2,          1, GAIN_ONE, MODE_RELEASE},
            '{0, 0, 32'd3,          0, 0, MODE_ATTACK},
            '{1, REG_DECAY_LEN,     32'd100, 0, 0, MODE_ATTACK},
            '{1, REG_SUSTAIN_LEVEL, 32'd0,   0, 0, MODE_ATTACK},
            '{0, 0, 32'd0,          1, GAIN_ONE, MODE_DECAY},
            '{0, 0, 32'd50,         0, 0, MODE_ATTACK},
            '{0, 0, 32'd100,        0, 0, MODE_ATTACK}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (steps[i]) begin
            s = steps[i];
            if (s.is_cfg) begin
                if (i == 0 || !steps[i-1].is_cfg) drain();
                write_reg(s.reg_idx, CFG_DW'(s.val));
            end else begin
                pause(pick_gap());
                send_index(s.val, s.typed, s.gain, s.mode);
            end
        end

        for (int p = 0; p < 10; p++) begin
            drain();
            if (p == 0) begin
                write_reg(REG_ATTACK_LEN, '1);
                write_reg(REG_DECAY_LEN, '1);
                write_reg(REG_SUSTAIN_LEN, 25'hFFFFFF);
                write_reg(REG_SUSTAIN_LEVEL, '1);
                write_reg(REG_RELEASE_TAU, '1);
            end else if (p == 1) begin
                write_reg(REG_ATTACK_LEN, '0);
                write_reg(REG_DECAY_LEN, '0);
                write_reg(REG_SUSTAIN_LEN, '0);
                write_reg(REG_SUSTAIN_LEVEL, '0);
                write_reg(REG_RELEASE_TAU, 25'd1);
            end else begin
                random_config();
            end
            no_gaps = (p % 3 == 2);
            for (int n = 0; n < 130; n++) begin
                if (!no_gaps) pause(pick_gap());
                send_index(pick_index(), 0, 0, MODE_ATTACK);
            end
        end

        drain();
        repeat (60) @(negedge i_clk);
        if (pending_words.size() != 0) n_errors = n_errors + 1;
        if (n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
